@@ sv/lru_cache_with_expiry_unit_macros.svh @@
// Assertion helpers used by the port checker lcx_chk.
`ifndef LRU_CACHE_WITH_EXPIRY_UNIT_MACROS_SVH
`define LRU_CACHE_WITH_EXPIRY_UNIT_MACROS_SVH

// same-cycle implication
`define LCX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcx check failed");

// next-cycle implication
`define LCX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcx check failed");

`endif

@@ sv/lcx_pkg.sv @@
package lcx_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_BITS  = 4;
  localparam int CNT_BITS  = 5;
  localparam int RANK_BITS = 4;
  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 64;
  localparam int TIME_BITS = 32;
  localparam int LIFE_BITS = 16;

  // operation codes
  localparam logic [2:0] F_GET     = 3'd0;
  localparam logic [2:0] F_PUT     = 3'd1;
  localparam logic [2:0] F_EXISTS  = 3'd2;
  localparam logic [2:0] F_REMOVE  = 3'd3;
  localparam logic [2:0] F_CLEAR   = 3'd4;
  localparam logic [2:0] F_CLEANUP = 3'd5;
  localparam logic [2:0] F_TRIM    = 3'd6;

  // register indexes
  localparam logic REG_MAX_ENTRIES      = 1'b0;
  localparam logic REG_DEFAULT_LIFETIME = 1'b1;

  typedef struct packed {
    logic [2:0]           func;
    logic [KEY_BITS-1:0]  key_tag;
    logic [DATA_BITS-1:0] data_word;
    logic [LIFE_BITS-1:0] lifetime;
    logic                 use_default_lifetime;
    logic [TIME_BITS-1:0] current_time;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [DATA_BITS-1:0] read_data;
    logic                 evicted;
    logic [CNT_BITS-1:0]  removed_count;
    logic [CNT_BITS-1:0]  entry_count;
    logic [31:0]          hit_total;
    logic [31:0]          miss_total;
    logic [31:0]          eviction_total;
  } out_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data;
    logic [TIME_BITS-1:0] expiry;
    logic [RANK_BITS-1:0] rank;
  } rec_t;

  localparam int REC_BITS = $bits(rec_t);

  typedef struct packed {
    logic hit_inc;
    logic miss_inc;
    logic evict_inc;
    logic clear;
  } stats_cmd_t;

endpackage

@@ sv/lcx_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data.
module lcx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/lcx_stats.sv @@
// Saturating hit / miss / eviction counters.
module lcx_stats (
  input  logic              clk,
  input  logic              rst,
  input  lcx_pkg::stats_cmd_t cmd,
  output logic [31:0]       hit_total,
  output logic [31:0]       miss_total,
  output logic [31:0]       eviction_total
);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else begin
      if (cmd.hit_inc && hit_total != '1) begin
        hit_total <= hit_total + 32'd1;
      end
      if (cmd.miss_inc && miss_total != '1) begin
        miss_total <= miss_total + 32'd1;
      end
      if (cmd.evict_inc && eviction_total != '1) begin
        eviction_total <= eviction_total + 32'd1;
      end
    end
  end

endmodule

@@ sv/lru_cache_with_expiry_unit.sv @@
// LRU key/value store with per-entry expiry, 16 entries.
// Input channel (in_valid/in_ready/in_word) takes one operation word: get, put,
// exists, remove, clear, cleanup or trim. Output channel (out_valid/out_ready/
// out_word) returns exactly one result word per operation, in order.
// Config port: cfg_we with cfg_index 0 (max_entries) or 1 (default_lifetime);
// write only while the block is idle.
// One word is worked on at a time. Entry records live in one RAM; every pass
// over it reads all 16 entries through the registered read port. A scan pass
// finds the key, the oldest entry and the first expired entry; an update pass
// rewrites recency ranks. Trim runs one scan per eviction and cleanup one
// scan/update round per dropped entry. The next word is taken in the cycle
// after the result is loaded.
// The result sits in an output register, so a stalled receiver only holds
// the block once a second result is ready.
// Reset empties the store, zeroes the counters, restores max_entries 16 and
// default_lifetime 300. No clearing pass is needed: entry valid bits are flops.
module lru_cache_with_expiry_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lcx_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output lcx_pkg::out_t out_word,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_SLOT = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [1:0] M_DROP   = 2'd0;
  localparam logic [1:0] M_RECENT = 2'd1;
  localparam logic [1:0] M_INSERT = 2'd2;

  localparam int IB = lcx_pkg::IDX_BITS;
  localparam int CB = lcx_pkg::CNT_BITS;
  localparam int RB = lcx_pkg::RANK_BITS;
  localparam int TB = lcx_pkg::TIME_BITS;
  localparam logic [IB-1:0] LAST_IDX = IB'(lcx_pkg::CAPACITY - 1);
  localparam logic [CB-1:0] CAP_CNT  = CB'(lcx_pkg::CAPACITY);

  logic [2:0] state;
  logic [CB-1:0] cnt;
  logic pv;
  logic [IB-1:0] pidx;
  logic [lcx_pkg::CAPACITY-1:0] valid;
  logic [CB-1:0] count;
  logic [4:0] max_entries;
  logic [15:0] def_life;

  // latched operation
  logic [2:0] func_q;
  logic [lcx_pkg::KEY_BITS-1:0] key_q;
  logic [lcx_pkg::DATA_BITS-1:0] data_q;
  logic [TB-1:0] exp_q;
  logic [TB-1:0] now_q;

  // scan results
  logic hit, hit_exp, ex_hit;
  logic [IB-1:0] hit_idx, old_idx, ex_idx;
  logic [RB-1:0] hit_rank, ex_rank;
  logic [lcx_pkg::DATA_BITS-1:0] hit_data;

  // update pass control
  logic [1:0] mode;
  logic [IB-1:0] tgt;
  logic [RB-1:0] ref_rank;
  logic upd_data;

  // result fields
  logic found;
  logic [lcx_pkg::DATA_BITS-1:0] rdata;
  logic evicted;
  logic [CB-1:0] removed;

  logic ram_re, ram_we;
  logic [lcx_pkg::REC_BITS-1:0] ram_rd;
  lcx_pkg::rec_t rd_rec, wr_rec;
  lcx_pkg::stats_cmd_t scmd;
  logic [31:0] hit_total, miss_total, eviction_total;

  logic [CB-1:0] lim;
  logic [15:0] life_sel;
  logic [TB:0] exp_sum;
  logic [IB-1:0] free_idx;
  logic v_cur, key_m, is_old, is_exp, get_hit, put_evict;

  assign rd_rec   = lcx_pkg::rec_t'(ram_rd);
  assign in_ready = (state == S_IDLE);
  assign lim      = (max_entries > CAP_CNT) ? CAP_CNT : max_entries;

  // expiry for put, saturating at the top of the time range
  assign life_sel = in_word.use_default_lifetime ? def_life : in_word.lifetime;
  assign exp_sum  = {1'b0, in_word.current_time} + (TB + 1)'(life_sel);

  // per-entry compares on the word coming out of the RAM
  assign v_cur  = valid[pidx];
  assign key_m  = v_cur && (rd_rec.key == key_q);
  assign is_old = v_cur && ({1'b0, rd_rec.rank} == (count - CB'(1)));
  assign is_exp = v_cur && (now_q > rd_rec.expiry);

  assign get_hit   = hit && !hit_exp;
  assign put_evict = !hit && (count >= lim) && (count != '0);

  // first free slot
  always_comb begin
    free_idx = '0;
    for (int i = lcx_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IB'(i);
      end
    end
  end

  // counter pulses
  always_comb begin
    scmd = '0;
    if (state == S_DEC) begin
      scmd.hit_inc   = (func_q == lcx_pkg::F_GET) && get_hit;
      scmd.miss_inc  = (func_q == lcx_pkg::F_GET) && !get_hit;
      scmd.evict_inc = ((func_q == lcx_pkg::F_PUT) && put_evict) ||
                       ((func_q == lcx_pkg::F_TRIM) && (count > lim));
      scmd.clear     = (func_q == lcx_pkg::F_CLEAR);
    end
  end

  // record rewrite during an update pass: ranks, and key/data/expiry of the target
  always_comb begin
    ram_we = 1'b0;
    wr_rec = rd_rec;
    if (state == S_UPD && pv) begin
      case (mode)
        M_DROP: begin
          if (v_cur && rd_rec.rank > ref_rank) begin
            wr_rec.rank = rd_rec.rank - RB'(1);
            ram_we = 1'b1;
          end
        end
        M_RECENT: begin
          if (pidx == tgt) begin
            wr_rec.rank = '0;
            if (upd_data) begin
              wr_rec.data   = data_q;
              wr_rec.expiry = exp_q;
            end
            ram_we = 1'b1;
          end else if (v_cur && rd_rec.rank < ref_rank) begin
            wr_rec.rank = rd_rec.rank + RB'(1);
            ram_we = 1'b1;
          end
        end
        M_INSERT: begin
          if (pidx == tgt) begin
            wr_rec.key    = key_q;
            wr_rec.data   = data_q;
            wr_rec.expiry = exp_q;
            wr_rec.rank   = '0;
            ram_we = 1'b1;
          end else if (v_cur) begin
            wr_rec.rank = rd_rec.rank + RB'(1);
            ram_we = 1'b1;
          end
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  // reads run one address ahead of the write, so no same-entry overlap
  assign ram_re = (state == S_SCAN || state == S_UPD) && !cnt[IB];

  lcx_ram #(
    .WIDTH(lcx_pkg::REC_BITS),
    .DEPTH(lcx_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pidx),
    .wdata(wr_rec),
    .re   (ram_re),
    .raddr(cnt[IB-1:0]),
    .rdata(ram_rd)
  );

  lcx_stats u_stats (
    .clk           (clk),
    .rst           (rst),
    .cmd           (scmd),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .eviction_total(eviction_total)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      pv          <= 1'b0;
      valid       <= '0;
      count       <= '0;
      max_entries <= 5'd16;
      def_life    <= 16'd300;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lcx_pkg::REG_MAX_ENTRIES:      max_entries <= cfg_data[4:0];
          lcx_pkg::REG_DEFAULT_LIFETIME: def_life    <= cfg_data;
          default: ;
        endcase
      end

      // result taken; a new one loading in S_FIN keeps it set
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      // address issue and read pipeline
      if (state == S_SCAN || state == S_UPD) begin
        pv   <= !cnt[IB];
        pidx <= cnt[IB-1:0];
        if (!cnt[IB]) begin
          cnt <= cnt + CB'(1);
        end
      end else begin
        pv <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q  <= in_word.func;
            key_q   <= in_word.key_tag;
            data_q  <= in_word.data_word;
            now_q   <= in_word.current_time;
            exp_q   <= exp_sum[TB] ? '1 : exp_sum[TB-1:0];
            found   <= 1'b0;
            rdata   <= '0;
            evicted <= 1'b0;
            removed <= '0;
            cnt     <= '0;
            hit     <= 1'b0;
            ex_hit  <= 1'b0;
            state   <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (pv) begin
            if (key_m && !hit) begin
              hit      <= 1'b1;
              hit_idx  <= pidx;
              hit_rank <= rd_rec.rank;
              hit_exp  <= now_q > rd_rec.expiry;
              hit_data <= rd_rec.data;
            end
            if (is_old) begin
              old_idx <= pidx;
            end
            if (is_exp && !ex_hit) begin
              ex_hit  <= 1'b1;
              ex_idx  <= pidx;
              ex_rank <= rd_rec.rank;
            end
            if (pidx == LAST_IDX) begin
              state <= S_DEC;
            end
          end
        end

        S_DEC: begin
          cnt <= '0;
          case (func_q)
            lcx_pkg::F_GET: begin
              if (get_hit) begin
                found    <= 1'b1;
                rdata    <= hit_data;
                mode     <= M_RECENT;
                tgt      <= hit_idx;
                ref_rank <= hit_rank;
                upd_data <= 1'b0;
                state    <= S_UPD;
              end else if (hit) begin
                valid[hit_idx] <= 1'b0;
                count    <= count - CB'(1);
                mode     <= M_DROP;
                ref_rank <= hit_rank;
                state    <= S_UPD;
              end else begin
                state <= S_FIN;
              end
            end
            lcx_pkg::F_PUT: begin
              if (hit) begin
                mode     <= M_RECENT;
                tgt      <= hit_idx;
                ref_rank <= hit_rank;
                upd_data <= 1'b1;
                state    <= S_UPD;
              end else begin
                // oldest holds the top rank, so no ranks shift on its removal
                if (put_evict) begin
                  valid[old_idx] <= 1'b0;
                  count   <= count - CB'(1);
                  evicted <= 1'b1;
                end
                state <= S_SLOT;
              end
            end
            lcx_pkg::F_EXISTS: begin
              if (hit && hit_exp) begin
                valid[hit_idx] <= 1'b0;
                count    <= count - CB'(1);
                mode     <= M_DROP;
                ref_rank <= hit_rank;
                state    <= S_UPD;
              end else begin
                if (hit) begin
                  found <= 1'b1;
                end
                state <= S_FIN;
              end
            end
            lcx_pkg::F_REMOVE: begin
              if (hit) begin
                valid[hit_idx] <= 1'b0;
                count    <= count - CB'(1);
                found    <= 1'b1;
                mode     <= M_DROP;
                ref_rank <= hit_rank;
                state    <= S_UPD;
              end else begin
                state <= S_FIN;
              end
            end
            lcx_pkg::F_CLEAR: begin
              valid <= '0;
              count <= '0;
              state <= S_FIN;
            end
            lcx_pkg::F_CLEANUP: begin
              // one expired entry per scan/update round
              if (ex_hit) begin
                valid[ex_idx] <= 1'b0;
                count    <= count - CB'(1);
                removed  <= removed + CB'(1);
                mode     <= M_DROP;
                ref_rank <= ex_rank;
                state    <= S_UPD;
              end else begin
                state <= S_FIN;
              end
            end
            lcx_pkg::F_TRIM: begin
              if (count > lim) begin
                valid[old_idx] <= 1'b0;
                count   <= count - CB'(1);
                removed <= removed + CB'(1);
                evicted <= 1'b1;
                hit     <= 1'b0;
                ex_hit  <= 1'b0;
                state   <= S_SCAN;
              end else begin
                state <= S_FIN;
              end
            end
            default: state <= S_FIN;
          endcase
        end

        S_SLOT: begin
          tgt   <= free_idx;
          mode  <= M_INSERT;
          cnt   <= '0;
          state <= S_UPD;
        end

        S_UPD: begin
          if (pv && pidx == LAST_IDX) begin
            if (mode == M_INSERT) begin
              valid[tgt] <= 1'b1;
              count      <= count + CB'(1);
            end
            if (func_q == lcx_pkg::F_CLEANUP) begin
              cnt     <= '0;
              hit     <= 1'b0;
              ex_hit  <= 1'b0;
              state   <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end

        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_word.found           <= found;
            out_word.read_data       <= rdata;
            out_word.evicted         <= evicted;
            out_word.removed_count   <= removed;
            out_word.entry_count     <= count;
            out_word.hit_total       <= hit_total;
            out_word.miss_total      <= miss_total;
            out_word.eviction_total  <= eviction_total;
            state                    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/lcx_chk.sv @@
`include "lru_cache_with_expiry_unit_macros.svh"

// Port-level checks for the cache unit.
module lcx_chk (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input lcx_pkg::out_t out_word
);

  // one word in flight: busy right after an accept
  `LCX_ASSERT_NEXT(busy_after_accept, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `LCX_ASSERT_NEXT(out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // never more entries than slots
  `LCX_ASSERT_NOW(count_bound, out_valid, out_word.entry_count <= 5'd16)

  // read data only on a hit
  `LCX_ASSERT_NOW(data_on_hit, out_valid && !out_word.found, out_word.read_data == 64'd0)

endmodule

bind lru_cache_with_expiry_unit lcx_chk u_lcx_chk (.*);
